### design/mas_pkg.sv
package mas_pkg;

  localparam int unsigned MaxLen = 1024;
  localparam int unsigned PosW   = 11;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreat  = 8'h3E;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChRbrack = 8'h5D;

  typedef enum logic [3:0] {
    C_AT,
    C_LBRACK,
    C_RBRACK,
    C_COMMA,
    C_COLON,
    C_DQUOTE,
    C_BSLASH,
    C_HOST,
    C_PLAIN,
    C_SPECIAL,
    C_CTRL,
    C_HIGH
  } mas_class_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_LONG = 2'd2
  } mas_status_e;

  typedef struct packed {
    logic       is_char;
    mas_class_e cls;
    logic       last;
  } mas_item_t;

  typedef struct packed {
    mas_status_e       status;
    logic [PosW-1:0]   mailbox_start;
    logic [PosW-1:0]   mailbox_end;
    logic              has_domain;
    logic [PosW-1:0]   domain_start;
    logic [PosW-1:0]   domain_end;
    logic              mailbox_quoted;
    logic              mailbox_empty;
  } mas_result_t;

endpackage

### design/mas_front.sv
module mas_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        char_byte_i,
  input  logic              no_char_i,
  input  logic              last_char_i,
  input  logic              full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output mas_pkg::mas_item_t item_o
);
  import mas_pkg::*;

  logic ended_q, ended_d;
  logic accept;
  logic live;

  function automatic mas_class_e classify(input logic [7:0] c);
    mas_class_e r;
    r = C_PLAIN;
    if (c == ChAt) begin
      r = C_AT;
    end else if (c == ChLbrack) begin
      r = C_LBRACK;
    end else if (c == ChRbrack) begin
      r = C_RBRACK;
    end else if (c == ChComma) begin
      r = C_COMMA;
    end else if (c == ChColon) begin
      r = C_COLON;
    end else if (c == ChDquote) begin
      r = C_DQUOTE;
    end else if (c == ChBslash) begin
      r = C_BSLASH;
    end else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                 (c >= 8'h61 && c <= 8'h7A) || c == ChDot || c == ChDash) begin
      r = C_HOST;
    end else if (c == ChLess || c == ChGreat || c == ChLparen || c == ChRparen ||
                 c == ChSemi) begin
      r = C_SPECIAL;
    end else if (c <= ChSpace) begin
      r = C_CTRL;
    end else if (c[7]) begin
      r = C_HIGH;
    end
    return r;
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign live       = !no_char_i && !ended_q;

  assign item_o.is_char = live && (char_byte_i != ChNul);
  assign item_o.cls     = classify(char_byte_i);
  assign item_o.last    = last_char_i;
  assign push_o         = accept && (item_o.is_char || last_char_i);

  always_comb begin
    ended_d = ended_q;
    if (accept) begin
      if (last_char_i) begin
        ended_d = 1'b0;
      end else if (live && char_byte_i == ChNul) begin
        ended_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else begin
      ended_q <= ended_d;
    end
  end

endmodule

### design/mas_queue.sv
module mas_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mas_pkg::mas_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output mas_pkg::mas_item_t item_o
);
  import mas_pkg::*;

  mas_item_t          mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCntW'(QDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

### design/mas_back.sv
module mas_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  mas_pkg::mas_item_t   item_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output mas_pkg::mas_result_t res_o
);
  import mas_pkg::*;

  typedef enum logic [3:0] {
    P_START,
    P_RHOST_BEGIN,
    P_RHOST,
    P_RLIT,
    P_RLIT_DONE,
    P_RCOMMA,
    P_RCOLON,
    P_LOCAL,
    P_QUOTED,
    P_ESC_LOCAL,
    P_QEND,
    P_DOM_BEGIN,
    P_DHOST,
    P_DLIT,
    P_ESC_LIT,
    P_DLIT_CLOSED
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] ms_q, ms_d;
  logic [PosW-1:0] me_q, me_d;
  logic [PosW-1:0] ds_q, ds_d;
  mas_status_e     err_q, err_d;
  logic            quo_q, quo_d;
  logic            out_valid_q, out_valid_d;
  mas_result_t     res_q, res_d;

  logic            pop;
  logic            bad, first_en, local_en, term_en;
  logic            ok, hasdom;
  logic [PosW-1:0] fin_ms, fin_me;
  mas_class_e      cls;

  assign cls   = item_i.cls;
  assign pop   = item_valid_i && (!item_i.last || !out_valid_q || !out_stall_i);
  assign pop_o = pop;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    ms_d        = ms_q;
    me_d        = me_q;
    ds_d        = ds_q;
    err_d       = err_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    bad         = 1'b0;
    first_en    = 1'b0;
    local_en    = 1'b0;
    term_en     = 1'b0;
    ok          = 1'b0;
    hasdom      = 1'b0;
    fin_ms      = '0;
    fin_me      = '0;

    if (pop && item_i.is_char) begin
      if (pos_q >= PosW'(MaxLen)) begin
        err_d = ST_LONG;
      end else begin
        pos_d = pos_q + PosW'(1);
        if (err_q == ST_OK) begin
          case (phase_q)
            P_START: begin
              if (cls == C_AT) phase_d = P_RHOST_BEGIN;
              else first_en = 1'b1;
            end
            P_RHOST_BEGIN: begin
              if (cls == C_LBRACK) phase_d = P_RLIT;
              else if (cls == C_HOST) phase_d = P_RHOST;
              else term_en = 1'b1;
            end
            P_RHOST: begin
              if (cls != C_HOST) term_en = 1'b1;
            end
            P_RLIT: begin
              if (cls == C_RBRACK) phase_d = P_RLIT_DONE;
              else if (cls == C_BSLASH) phase_d = P_ESC_LIT;
            end
            P_RLIT_DONE: term_en = 1'b1;
            P_RCOMMA: begin
              if (cls == C_AT) phase_d = P_RHOST_BEGIN;
              else bad = 1'b1;
            end
            P_RCOLON: begin
              if (cls == C_AT) begin
                bad = 1'b1;
              end else begin
                ms_d     = pos_q;
                first_en = 1'b1;
              end
            end
            P_LOCAL: local_en = 1'b1;
            P_QUOTED: begin
              if (cls == C_DQUOTE) begin
                me_d    = pos_q + PosW'(1);
                phase_d = P_QEND;
              end else if (cls == C_BSLASH) begin
                phase_d = P_ESC_LOCAL;
              end
            end
            P_ESC_LOCAL: begin
              if (quo_q) phase_d = P_QUOTED;
              else if (cls == C_HIGH) bad = 1'b1;
              else phase_d = P_LOCAL;
            end
            P_QEND: begin
              if (cls == C_AT) begin
                ds_d    = pos_q + PosW'(1);
                phase_d = P_DOM_BEGIN;
              end else begin
                bad = 1'b1;
              end
            end
            P_DOM_BEGIN: begin
              if (cls == C_LBRACK) phase_d = P_DLIT;
              else if (cls == C_HOST) phase_d = P_DHOST;
              else bad = 1'b1;
            end
            P_DHOST: begin
              if (cls != C_HOST) bad = 1'b1;
            end
            P_DLIT: begin
              if (cls == C_RBRACK) begin
                if (pos_q == ds_q + PosW'(1)) bad = 1'b1;
                else phase_d = P_DLIT_CLOSED;
              end else if (cls == C_BSLASH) begin
                phase_d = P_ESC_LIT;
              end
            end
            P_ESC_LIT: phase_d = (ds_q != '0) ? P_DLIT : P_RLIT;
            P_DLIT_CLOSED: bad = 1'b1;
            default: bad = 1'b1;
          endcase

          if (term_en) begin
            if (cls == C_COMMA) phase_d = P_RCOMMA;
            else if (cls == C_COLON) phase_d = P_RCOLON;
            else bad = 1'b1;
          end

          if (first_en && cls == C_DQUOTE) begin
            quo_d   = 1'b1;
            phase_d = P_QUOTED;
          end else if (first_en || local_en) begin
            case (cls)
              C_AT: begin
                me_d    = pos_q;
                ds_d    = pos_q + PosW'(1);
                phase_d = P_DOM_BEGIN;
              end
              C_BSLASH: phase_d = P_ESC_LOCAL;
              C_HOST, C_PLAIN: phase_d = P_LOCAL;
              default: bad = 1'b1;
            endcase
          end

          if (bad) err_d = ST_BAD;
        end
      end
    end

    if (pop && item_i.last) begin
      fin_ms = ms_d;
      fin_me = me_d;
      if (err_d == ST_OK) begin
        case (phase_d)
          P_START, P_QEND: ok = 1'b1;
          P_RCOLON: begin
            ok     = 1'b1;
            fin_ms = pos_d;
            fin_me = pos_d;
          end
          P_LOCAL: begin
            ok     = 1'b1;
            fin_me = pos_d;
          end
          P_DHOST, P_DLIT_CLOSED: begin
            ok     = 1'b1;
            hasdom = 1'b1;
          end
          default: ok = 1'b0;
        endcase
      end
      res_d = '0;
      if (ok) begin
        res_d.status         = ST_OK;
        res_d.mailbox_start  = fin_ms;
        res_d.mailbox_end    = fin_me;
        res_d.has_domain     = hasdom;
        res_d.domain_start   = hasdom ? ds_d : '0;
        res_d.domain_end     = pos_d;
        res_d.mailbox_quoted = quo_d;
        res_d.mailbox_empty  = (fin_ms == fin_me);
      end else if (err_d == ST_LONG) begin
        res_d.status = ST_LONG;
      end else begin
        res_d.status = ST_BAD;
      end
      out_valid_d = 1'b1;
      phase_d     = P_START;
      pos_d       = '0;
      ms_d        = '0;
      me_d        = '0;
      ds_d        = '0;
      err_d       = ST_OK;
      quo_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_START;
      pos_q       <= '0;
      ms_q        <= '0;
      me_q        <= '0;
      ds_q        <= '0;
      err_q       <= ST_OK;
      quo_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      ms_q        <= ms_d;
      me_q        <= me_d;
      ds_q        <= ds_d;
      err_q       <= err_d;
      quo_q       <= quo_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MaxLen))
    else $error("position past limit");

  a_long_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q == ST_LONG |-> pos_q == PosW'(MaxLen))
    else $error("length error below limit");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && item_i.last) |=> (phase_q == P_START && pos_q == '0 && out_valid_q))
    else $error("parser did not restart after result");

endmodule

### design/mail_address_splitter_unit.sv
// With an empty queue, an accepted last input item is first written into the queue; the
// parser then pops it and registers the result together with the output valid.
// Throughput: one input item per cycle; a four-entry queue between the classifier
// and the parser absorbs output stalls, and stall rises only when that queue fills.
// An address is parsed item by item, with its result on the last item.
// Reset (rst_ni low, asynchronous) clears the queue, the parser and the output valid.
module mail_address_splitter_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               char_byte_i,
  input  logic                     no_char_i,
  input  logic                     last_char_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [mas_pkg::PosW-1:0] mailbox_start_o,
  output logic [mas_pkg::PosW-1:0] mailbox_end_o,
  output logic                     has_domain_o,
  output logic [mas_pkg::PosW-1:0] domain_start_o,
  output logic [mas_pkg::PosW-1:0] domain_end_o,
  output logic                     mailbox_quoted_o,
  output logic                     mailbox_empty_o
);
  import mas_pkg::*;

  logic        full, push, pop, q_valid;
  mas_item_t   f_item, q_item;
  mas_result_t res;

  mas_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .char_byte_i (char_byte_i),
    .no_char_i   (no_char_i),
    .last_char_i (last_char_i),
    .full_i      (full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .item_o      (f_item)
  );

  mas_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  mas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .res_o        (res)
  );

  assign status_o         = res.status;
  assign mailbox_start_o  = res.mailbox_start;
  assign mailbox_end_o    = res.mailbox_end;
  assign has_domain_o     = res.has_domain;
  assign domain_start_o   = res.domain_start;
  assign domain_end_o     = res.domain_end;
  assign mailbox_quoted_o = res.mailbox_quoted;
  assign mailbox_empty_o  = res.mailbox_empty;

endmodule
